// ----- sv/sebfr_pkg.sv -----
package sebfr_pkg;

  // command codes carried on the action field
  typedef enum logic [1:0] {
    ACT_RECV  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // frame delimiters
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'hBB;

  // output queue geometry
  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 2;

  // one result word
  typedef struct packed {
    logic       frame_done;
    logic       frame_active;
    logic [5:0] byte_count;
    logic [7:0] read_data;
  } result_t;

endpackage

// ----- sv/start_end_byte_frame_receiver.sv -----
// Start/end delimited frame receiver. Each input word carries an action: receive a
// byte, read one stored payload entry, or clear the frame status. Bytes after the
// start byte 0xAA are stored at the running count; the end byte 0xBB marks the frame
// done and stores 0 at the count without advancing it; a start byte always restarts
// the frame, and reaching BUF_DEPTH stored bytes drops the frame. One word is taken
// every cycle while the input is not stalled; its result word passes through the read
// stage, which holds the registered read port of the payload memory, and then a
// three-entry output queue that keeps the input flowing while the output side stalls;
// the input stalls once the memory read stage and that queue together hold three
// words, so a word in the read stage always finds room in the queue. The payload
// memory needs no clearing after reset.
module start_end_byte_frame_receiver #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] rx_byte_i,
  input  logic [5:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_done_o,
  output logic       frame_active_o,
  output logic [5:0] byte_count_o,
  output logic [7:0] read_data_o
);

  localparam int unsigned CW = $clog2(BUF_DEPTH);
  localparam int unsigned OW = (CW > 6) ? CW : 6;

  logic                 accept;
  logic                 done_q, done_d;
  logic                 active_q, active_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW:0]          count_n;
  logic [CW:0]          count_inc;
  logic                 ram_we;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [CW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;
  logic [CW+5:0]        idx_ext;
  logic                 idx_in_range;
  logic [OW-1:0]        count_ext;

  // read stage between acceptance and the output queue
  logic                 s1_valid_q;
  logic                 s1_done_q;
  logic                 s1_active_q;
  logic [5:0]           s1_count_q;
  logic                 s1_rd_q;
  sebfr_pkg::result_t   s1_res;
  sebfr_pkg::result_t   out_res;
  logic [sebfr_pkg::OUT_CNT_W-1:0] q_count;
  logic [2:0]           occupancy;

  // input flow control from registered occupancy only
  assign occupancy  = 3'(q_count) + 3'(s1_valid_q);
  assign in_stall_o = (occupancy >= 3'(sebfr_pkg::OUT_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // read address and range check
  assign idx_ext      = (CW + 6)'(read_index_i);
  assign ram_raddr    = idx_ext[CW-1:0];
  assign idx_in_range = (32'(read_index_i) < BUF_DEPTH);

  assign count_inc = {1'b0, count_q} + 1'b1;

  // frame state update
  always_comb begin
    done_d    = done_q;
    active_d  = active_q;
    count_n   = {1'b0, count_q};
    ram_we    = 1'b0;
    ram_wdata = rx_byte_i;
    ram_re    = 1'b0;
    if (accept) begin
      case (action_i)
        sebfr_pkg::ACT_RECV: begin
          if (active_q) begin
            ram_we = 1'b1;
            if (rx_byte_i == sebfr_pkg::END_BYTE) begin
              done_d    = 1'b1;
              ram_wdata = '0;
            end else begin
              count_n = count_inc;
            end
          end
          if (rx_byte_i == sebfr_pkg::START_BYTE) begin
            count_n  = '0;
            done_d   = 1'b0;
            active_d = 1'b1;
          end
          if (count_n == (CW + 1)'(BUF_DEPTH)) begin
            count_n  = '0;
            done_d   = 1'b0;
            active_d = 1'b0;
          end
        end
        sebfr_pkg::ACT_READ: begin
          ram_re = idx_in_range;
        end
        sebfr_pkg::ACT_CLEAR: begin
          count_n  = '0;
          done_d   = 1'b0;
          active_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
    count_d = count_n[CW-1:0];
  end

  assign count_ext = OW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      active_q   <= 1'b0;
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      done_q     <= done_d;
      active_q   <= active_d;
      count_q    <= count_d;
      s1_valid_q <= accept;
    end
  end

  // status captured alongside the memory read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_done_q   <= done_d;
      s1_active_q <= active_d;
      s1_count_q  <= count_ext[5:0];
      s1_rd_q     <= ram_re;
    end
  end

  sebfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // assemble the result word
  always_comb begin
    s1_res.frame_done   = s1_done_q;
    s1_res.frame_active = s1_active_q;
    s1_res.byte_count   = s1_count_q;
    s1_res.read_data    = s1_rd_q ? ram_rdata : 8'd0;
  end

  sebfr_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .data_i  (s1_res),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (out_res),
    .count_o (q_count)
  );

  assign frame_done_o   = out_res.frame_done;
  assign frame_active_o = out_res.frame_active;
  assign byte_count_o   = out_res.byte_count;
  assign read_data_o    = out_res.read_data;

endmodule

// ----- sv/sebfr_ram.sv -----
module sebfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sebfr_out_fifo.sv -----
module sebfr_out_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  sebfr_pkg::result_t                  data_i,
  input  logic                                pop_i,
  output logic                                valid_o,
  output sebfr_pkg::result_t                  data_o,
  output logic [sebfr_pkg::OUT_CNT_W-1:0]     count_o
);

  sebfr_pkg::result_t                      mem_q [sebfr_pkg::OUT_DEPTH];
  logic [sebfr_pkg::OUT_PTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [sebfr_pkg::OUT_PTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [sebfr_pkg::OUT_CNT_W-1:0]         cnt_q, cnt_d;
  logic                                    do_pop;

  localparam logic [sebfr_pkg::OUT_PTR_W-1:0] LastPtr =
    sebfr_pkg::OUT_PTR_W'(sebfr_pkg::OUT_DEPTH - 1);

  assign do_pop = pop_i && (cnt_q != '0);

  // pointer and fill level updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule
